// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the glob matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define GWM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/gwm_pkg.sv =====
// Shared constants, types and helpers of the glob wildcard matcher.
package gwm_pkg;

  // Pattern capacity and derived widths
  localparam int unsigned PatMax   = 32;
  localparam int unsigned LenW     = $clog2(PatMax + 1);
  localparam int unsigned IdxW     = (PatMax > 1) ? $clog2(PatMax) : 1;
  localparam int unsigned VecW     = PatMax + 1;
  localparam int unsigned ScanLvls = $clog2(VecW);

  localparam logic [LenW-1:0] PatFull = LenW'(PatMax);

  // Special pattern characters
  localparam logic [7:0] CharStar = 8'h2A;
  localparam logic [7:0] CharAny  = 8'h3F;
  localparam logic [7:0] CharNul  = 8'h00;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdName   = 2'd2,
    CmdEnd    = 2'd3
  } gwm_cmd_e;

  // Stored pattern as seen by the position tracker
  typedef struct packed {
    logic [PatMax-1:0][7:0] folded;   // case-folded pattern bytes
    logic [PatMax-1:0]      star;     // position holds '*'
    logic [PatMax-1:0]      any;      // position holds '?'
    logic [PatMax-1:0]      filled;   // position is below the length
    logic [LenW-1:0]        len;
    logic                   overflow;
  } gwm_pat_t;

  // ASCII case folding, upper to lower
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/glob_wildcard_matcher.sv =====
// Top level of the case-insensitive streaming glob matcher.
//
// Input channel (in_valid_i / in_ready_o): one word per item, cmd_i and
// char_byte_i. Clear empties the pattern; append adds one pattern byte
// ('*' any run, '?' any one byte, others match case-folded); name feeds one
// byte of the name under test; end of name yields one result word. Zero
// bytes are ignored. Pattern bytes past 32 are dropped and flagged.
// Output channel (out_valid_o / out_ready_i): matched_o and
// pattern_truncated_o, one word per end-of-name.
// Result path: an accepted end-of-name word sits in the input register,
// then its verdict is loaded into the result register. Throughput is one
// word per cycle while no end-of-name word waits on a pending result,
// set by the combinational closure and advance of the 33-bit position
// vector.
// Reset: the pattern is empty, its overflow flag is clear and both
// channels are empty.
// Stall: while a result word waits, pattern and name words keep flowing;
// a further end-of-name word waits in the input register and ready drops
// until the result word is taken.
`include "assert_macros.svh"

module glob_wildcard_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       matched_o,
  output logic       pattern_truncated_o
);

  logic              in_valid_q, in_valid_d;
  gwm_pkg::gwm_cmd_e cmd_q;
  logic [7:0]        byte_q;
  logic              out_valid_q, out_valid_d;
  logic              matched_q;
  logic              trunc_q;
  logic              in_take;
  logic              in_adv;
  logic              is_end;
  logic              byte_nz;
  logic              nfa_match;
  gwm_pkg::gwm_pat_t pat;

  // Input register handshake
  assign is_end     = (cmd_q == gwm_pkg::CmdEnd);
  assign in_adv     = in_valid_q && (!is_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || in_adv;
  assign in_take    = in_valid_i && in_ready_o;
  assign byte_nz    = (byte_q != gwm_pkg::CharNul);

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (in_adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= gwm_pkg::gwm_cmd_e'(cmd_i);
      byte_q <= char_byte_i;
    end
  end

  // Pattern store
  gwm_pattern u_pattern (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (in_adv && (cmd_q == gwm_pkg::CmdClear)),
    .append_i (in_adv && (cmd_q == gwm_pkg::CmdAppend) && byte_nz),
    .byte_i   (byte_q),
    .pat_o    (pat)
  );

  // Position tracker
  gwm_nfa u_nfa (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pat_i     (pat),
    .clear_i   (in_adv && (cmd_q == gwm_pkg::CmdClear)),
    .step_i    (in_adv && (cmd_q == gwm_pkg::CmdName) && byte_nz),
    .end_i     (in_adv && is_end),
    .byte_i    (byte_q),
    .matched_o (nfa_match)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_adv && is_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && is_end) begin
      matched_q <= nfa_match;
      trunc_q   <= pat.overflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign matched_o           = matched_q;
  assign pattern_truncated_o = trunc_q;

  // Checks
  `GWM_ASSERT(a_end_gives_word, (in_adv && is_end) |=> out_valid_q, "end of name without result")
  `GWM_ASSERT(a_clear_drops_flag, (in_adv && cmd_q == gwm_pkg::CmdClear) |=> !pat.overflow, "overflow kept over clear")
  `GWM_ASSERT_NEVER(a_len_bound, pat.len > gwm_pkg::PatFull, "pattern length past capacity")
  `GWM_ASSERT(a_ovf_when_full, pat.overflow |-> (pat.len == gwm_pkg::PatFull), "overflow with room left")

endmodule

// ===== hw/rtl/gwm_pattern.sv =====
// Pattern storage: folded bytes, per-position flags, length and overflow flag.
module gwm_pattern (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              append_i,
  input  logic [7:0]        byte_i,
  output gwm_pkg::gwm_pat_t pat_o
);

  logic [gwm_pkg::PatMax-1:0][7:0] folded_q;
  logic [gwm_pkg::PatMax-1:0]      star_q, star_d;
  logic [gwm_pkg::PatMax-1:0]      any_q, any_d;
  logic [gwm_pkg::PatMax-1:0]      filled_q, filled_d;
  logic [gwm_pkg::LenW-1:0]        len_q, len_d;
  logic                            ovf_q, ovf_d;
  logic                            room;
  logic                            wr_en;
  logic [gwm_pkg::IdxW-1:0]        wr_idx;

  assign room   = (len_q < gwm_pkg::PatFull);
  assign wr_en  = append_i && room;
  assign wr_idx = len_q[gwm_pkg::IdxW-1:0];

  // Next state of the flags and length
  always_comb begin
    star_d   = star_q;
    any_d    = any_q;
    filled_d = filled_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    if (clear_i) begin
      star_d   = '0;
      any_d    = '0;
      filled_d = '0;
      len_d    = '0;
      ovf_d    = 1'b0;
    end else if (append_i) begin
      if (room) begin
        star_d[wr_idx]   = (byte_i == gwm_pkg::CharStar);
        any_d[wr_idx]    = (byte_i == gwm_pkg::CharAny);
        filled_d[wr_idx] = 1'b1;
        len_d            = len_q + gwm_pkg::LenW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      star_q   <= '0;
      any_q    <= '0;
      filled_q <= '0;
      len_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      star_q   <= star_d;
      any_q    <= any_d;
      filled_q <= filled_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
    end
  end

  // Byte store, written at the current length
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      folded_q[wr_idx] <= gwm_pkg::fold_case(byte_i);
    end
  end

  assign pat_o.folded   = folded_q;
  assign pat_o.star     = star_q;
  assign pat_o.any      = any_q;
  assign pat_o.filled   = filled_q;
  assign pat_o.len      = len_q;
  assign pat_o.overflow = ovf_q;

endmodule

// ===== hw/rtl/gwm_nfa.sv =====
// Active position vector with star closure, per-byte advance and match check.
module gwm_nfa (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gwm_pkg::gwm_pat_t pat_i,
  input  logic              clear_i,
  input  logic              step_i,
  input  logic              end_i,
  input  logic [7:0]        byte_i,
  output logic              matched_o
);

  localparam logic [gwm_pkg::VecW-1:0] VecStart = gwm_pkg::VecW'(1);

  logic [gwm_pkg::VecW-1:0]                  vec_q, vec_d;
  logic [gwm_pkg::ScanLvls:0][gwm_pkg::VecW-1:0] gen, prop;
  logic [gwm_pkg::VecW-1:0]                  closed;
  logic [gwm_pkg::VecW-1:0]                  next_vec;
  logic [7:0]                                fc;

  // Star closure as a prefix scan: a set bit runs forward over star positions
  always_comb begin
    gen[0]  = vec_q;
    prop[0] = {pat_i.star & pat_i.filled, 1'b0};
    for (int l = 0; l < gwm_pkg::ScanLvls; l++) begin
      for (int k = 0; k < gwm_pkg::VecW; k++) begin
        if (k >= (1 << l)) begin
          gen[l+1][k]  = gen[l][k] | (prop[l][k] & gen[l][k-(1<<l)]);
          prop[l+1][k] = prop[l][k] & prop[l][k-(1<<l)];
        end else begin
          gen[l+1][k]  = gen[l][k];
          prop[l+1][k] = prop[l][k];
        end
      end
    end
  end

  assign closed = gen[gwm_pkg::ScanLvls];
  assign fc     = gwm_pkg::fold_case(byte_i);

  // One name byte: stars keep their position, matches move one on
  always_comb begin
    next_vec = '0;
    for (int i = 0; i < gwm_pkg::PatMax; i++) begin
      if (closed[i] && pat_i.filled[i]) begin
        if (pat_i.star[i]) begin
          next_vec[i] = 1'b1;
        end else if (pat_i.any[i] || (pat_i.folded[i] == fc)) begin
          next_vec[i+1] = 1'b1;
        end
      end
    end
  end

  // Vector update; restart after clear and after each result
  always_comb begin
    vec_d = vec_q;
    if (clear_i || end_i) begin
      vec_d = VecStart;
    end else if (step_i) begin
      vec_d = next_vec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= VecStart;
    end else begin
      vec_q <= vec_d;
    end
  end

  assign matched_o = closed[pat_i.len];

endmodule
